// ===== rtl/core/wavd_pkg.sv =====
// wavd_pkg: shared types and constants of the WAVE PCM stream decoder.
// Used by wavd_parser and wav_pcm_stream_decoder; depends on nothing else.
package wavd_pkg;

  // Four-character tags as they arrive, first character in the top byte
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [7:0]  SAMPLE_BIAS = 8'h80;

  // Result kinds
  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_BAD_TAG   = 3'd0;
  localparam logic [2:0] ERR_SHORT_FMT = 3'd1;
  localparam logic [2:0] ERR_FORMAT    = 3'd2;
  localparam logic [2:0] ERR_NO_FMT    = 3'd3;
  localparam logic [2:0] ERR_EOS_HDR   = 3'd4;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_HDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        pcm_rate;
    logic [1:0]         channel_count;
    logic [4:0]         sample_bits;
    logic [2:0]         error_code;
    logic               is_last;
  } result_t;

endpackage

// ===== rtl/core/wav_pcm_stream_decoder.sv =====
// wav_pcm_stream_decoder: top level of the byte-serial RIFF/WAVE PCM decoder.
// Depends on wavd_pkg and wavd_parser.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+----------------------------------
//   byte     | in        | byte_valid / byte_stall     | data_byte, stream_end
//   result   | out       | result_valid / result_stall | kind, left_sample, right_sample,
//            |           |                             | pcm_rate, channel_count,
//            |           |                             | sample_bits, error_code, is_last
//
// One byte beat per cycle sustained while byte_stall is low; a byte's result beat passes
// through the input register, then the parser step loads the result register.
// The parser state advances once per byte, in the cycle the byte leaves the input register.
// rst is synchronous and returns the parser to expecting a RIFF header; no clearing pass.
// While a result beat waits under result_stall, bytes that make no result keep flowing;
// a byte that makes a result holds in the input register until the result register frees.
module wav_pcm_stream_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic [31:0]        pcm_rate,
  output logic [1:0]         channel_count,
  output logic [4:0]         sample_bits,
  output logic [2:0]         error_code,
  output logic               is_last
);

  // Input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end;

  // Parser handshake
  logic              produce;
  logic              advance;
  wavd_pkg::result_t step_result;
  wavd_pkg::result_t held_result;

  wavd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_byte),
    .stream_end (in_end),
    .produce    (produce),
    .result     (step_result)
  );

  // Advance a held byte when it makes no result or the result register is free
  assign advance    = in_full && (!produce || !result_valid || !result_stall);
  assign byte_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!byte_stall) begin
      in_full <= byte_valid;
    end
  end

  // Capture payload only on an accepted beat
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= data_byte;
      in_end  <= stream_end;
    end
  end

  // Result register: load on a producing step, otherwise drop on a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && produce) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      held_result <= step_result;
    end
  end

  assign kind          = held_result.kind;
  assign left_sample   = held_result.left_sample;
  assign right_sample  = held_result.right_sample;
  assign pcm_rate      = held_result.pcm_rate;
  assign channel_count = held_result.channel_count;
  assign sample_bits   = held_result.sample_bits;
  assign error_code    = held_result.error_code;
  assign is_last       = held_result.is_last;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(held_result))
    else $error("stalled result beat changed or vanished");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> in_full)
    else $error("byte channel stalled with an empty input register");

  a_block_producer: assert property (@(posedge clk) disable iff (rst)
    in_full && produce && result_valid && result_stall |-> byte_stall)
    else $error("producing byte not held behind a stalled result");

endmodule

// ===== rtl/core/wavd_parser.sv =====
// wavd_parser: byte-serial RIFF/WAVE parser state and one-byte step logic.
// Depends on wavd_pkg (phase_t, result_t, tags and codes).
module wavd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output logic              produce,
  output wavd_pkg::result_t result
);

  wavd_pkg::phase_t phase, phase_next;
  logic [4:0]  byte_count, byte_count_next;
  logic [32:0] chunk_length, chunk_length_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [15:0] format_code, format_code_next;
  logic [1:0]  channels_held, channels_held_next;
  logic [31:0] rate_held, rate_held_next;
  logic [4:0]  bits_held, bits_held_next;
  logic        format_seen, format_seen_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [23:0] frame_held, frame_held_next;
  logic [1:0]  frame_idx, frame_idx_next;

  function automatic logic [15:0] le16(input logic [31:0] t);
    le16 = {t[7:0], t[15:8]};
  endfunction

  function automatic logic [31:0] le32(input logic [31:0] t);
    le32 = {t[7:0], t[15:8], t[23:16], t[31:24]};
  endfunction

  logic [31:0] shifted;
  logic [4:0]  cnt_inc;
  logic [31:0] size_le;
  logic [15:0] word_le;
  logic [32:0] chunk_dec;
  logic [31:0] rem_dec;
  logic [6:0]  fb_prod;
  logic [3:0]  fb_raw;
  logic [2:0]  fb;
  logic        emit;
  logic        fmt_bad;
  logic        riff_bad;

  assign shifted   = {tag_shift[23:0], data_byte};
  assign cnt_inc   = byte_count + 5'd1;
  assign size_le   = le32(shifted);
  assign word_le   = le16(shifted);
  assign chunk_dec = chunk_length - 33'd1;
  assign rem_dec   = data_remaining - 32'd1;
  assign fb_prod   = 7'(channels_held) * 7'(bits_held);
  assign fb_raw    = fb_prod[6:3];
  assign fb        = (fb_raw == 4'd0 || fb_raw > 4'd4) ? 3'd1 : fb_raw[2:0];
  assign emit      = ({1'b0, frame_idx} + 3'd1) >= fb;
  assign fmt_bad   = (format_code != wavd_pkg::FMT_PCM) ||
                     (word_le != 16'd8 && word_le != 16'd16) ||
                     (channels_held == 2'd0);
  assign riff_bad  = (cnt_inc == 5'd4 && shifted != wavd_pkg::TAG_RIFF) ||
                     (cnt_inc >= 5'd12 && shifted != wavd_pkg::TAG_WAVE);

  // Next state
  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    chunk_length_next   = chunk_length;
    tag_shift_next      = tag_shift;
    format_code_next    = format_code;
    channels_held_next  = channels_held;
    rate_held_next      = rate_held;
    bits_held_next      = bits_held;
    format_seen_next    = format_seen;
    data_remaining_next = data_remaining;
    frame_held_next     = frame_held;
    frame_idx_next      = frame_idx;
    if (stream_end) begin
      phase_next          = wavd_pkg::PH_RIFF;
      byte_count_next     = '0;
      chunk_length_next   = '0;
      tag_shift_next      = '0;
      format_code_next    = '0;
      channels_held_next  = '0;
      rate_held_next      = '0;
      bits_held_next      = '0;
      format_seen_next    = 1'b0;
      data_remaining_next = '0;
      frame_held_next     = '0;
      frame_idx_next      = '0;
    end else begin
      unique case (phase)
        wavd_pkg::PH_RIFF: begin
          tag_shift_next  = shifted;
          byte_count_next = cnt_inc;
          if (riff_bad) begin
            phase_next = wavd_pkg::PH_IDLE;
          end else if (cnt_inc >= 5'd12) begin
            phase_next      = wavd_pkg::PH_HDR;
            byte_count_next = '0;
          end
        end
        wavd_pkg::PH_HDR: begin
          tag_shift_next  = shifted;
          byte_count_next = cnt_inc;
          if (cnt_inc == 5'd4) begin
            chunk_length_next = {1'b0, shifted};
          end else if (cnt_inc >= 5'd8) begin
            byte_count_next = '0;
            if (chunk_length[31:0] == wavd_pkg::TAG_FMT) begin
              if (size_le < wavd_pkg::FMT_MIN_LEN) begin
                phase_next = wavd_pkg::PH_IDLE;
              end else begin
                chunk_length_next = {1'b0, size_le};
                phase_next        = wavd_pkg::PH_FMT;
              end
            end else if (chunk_length[31:0] == wavd_pkg::TAG_DATA) begin
              if (!format_seen) begin
                phase_next = wavd_pkg::PH_IDLE;
              end else begin
                data_remaining_next = size_le;
                frame_idx_next      = '0;
                frame_held_next     = '0;
                phase_next = (size_le != 32'd0) ? wavd_pkg::PH_DATA : wavd_pkg::PH_IDLE;
              end
            end else begin
              // skip the chunk and its word-alignment pad
              chunk_length_next = {1'b0, size_le} + {32'd0, size_le[0]};
              if (chunk_length_next != 33'd0) begin
                phase_next = wavd_pkg::PH_SKIP;
              end
            end
          end
        end
        wavd_pkg::PH_FMT: begin
          tag_shift_next    = shifted;
          chunk_length_next = chunk_dec;
          if (byte_count < 5'd16) begin
            byte_count_next = cnt_inc;
          end
          case (byte_count)
            5'd1: format_code_next = word_le;
            5'd3: channels_held_next = (word_le == 16'd1 || word_le == 16'd2) ?
                                       word_le[1:0] : 2'd0;
            5'd7: rate_held_next = size_le;
            5'd15: begin
              if (!fmt_bad) begin
                bits_held_next   = word_le[4:0];
                format_seen_next = 1'b1;
              end
            end
            default: ;
          endcase
          if (byte_count == 5'd15 && fmt_bad) begin
            phase_next = wavd_pkg::PH_IDLE;
          end else if (chunk_dec == 33'd0) begin
            phase_next      = wavd_pkg::PH_HDR;
            byte_count_next = '0;
          end
        end
        wavd_pkg::PH_SKIP: begin
          chunk_length_next = chunk_dec;
          if (chunk_dec == 33'd0) begin
            phase_next      = wavd_pkg::PH_HDR;
            byte_count_next = '0;
          end
        end
        wavd_pkg::PH_DATA: begin
          data_remaining_next = rem_dec;
          if (emit) begin
            frame_idx_next  = '0;
            frame_held_next = '0;
          end else begin
            frame_held_next = {frame_held[15:0], data_byte};
            frame_idx_next  = frame_idx + 2'd1;
          end
          if (rem_dec == 32'd0) begin
            phase_next = wavd_pkg::PH_IDLE;
          end
        end
        wavd_pkg::PH_IDLE: ;
        default: ;
      endcase
    end
  end

  // Result of the current byte
  always_comb begin
    result  = '0;
    produce = 1'b0;
    if (stream_end) begin
      produce = 1'b1;
      if (phase == wavd_pkg::PH_DATA || phase == wavd_pkg::PH_IDLE) begin
        result.kind = wavd_pkg::KIND_END;
      end else begin
        result.kind       = wavd_pkg::KIND_ERROR;
        result.error_code = wavd_pkg::ERR_EOS_HDR;
      end
    end else begin
      unique case (phase)
        wavd_pkg::PH_RIFF: begin
          if (riff_bad) begin
            produce           = 1'b1;
            result.kind       = wavd_pkg::KIND_ERROR;
            result.error_code = wavd_pkg::ERR_BAD_TAG;
          end
        end
        wavd_pkg::PH_HDR: begin
          if (cnt_inc == 5'd8) begin
            if (chunk_length[31:0] == wavd_pkg::TAG_FMT) begin
              if (size_le < wavd_pkg::FMT_MIN_LEN) begin
                produce           = 1'b1;
                result.kind       = wavd_pkg::KIND_ERROR;
                result.error_code = wavd_pkg::ERR_SHORT_FMT;
              end
            end else if (chunk_length[31:0] == wavd_pkg::TAG_DATA) begin
              produce = 1'b1;
              if (!format_seen) begin
                result.kind       = wavd_pkg::KIND_ERROR;
                result.error_code = wavd_pkg::ERR_NO_FMT;
              end else begin
                result.kind          = wavd_pkg::KIND_FORMAT;
                result.pcm_rate      = rate_held;
                result.channel_count = channels_held;
                result.sample_bits   = bits_held;
                result.is_last       = size_le < {29'd0, fb};
              end
            end
          end
        end
        wavd_pkg::PH_FMT: begin
          if (byte_count == 5'd15 && fmt_bad) begin
            produce           = 1'b1;
            result.kind       = wavd_pkg::KIND_ERROR;
            result.error_code = wavd_pkg::ERR_FORMAT;
          end
        end
        wavd_pkg::PH_DATA: begin
          if (emit) begin
            produce        = 1'b1;
            result.kind    = wavd_pkg::KIND_FRAME;
            result.is_last = rem_dec < {29'd0, fb};
            if (fb == 3'd1) begin
              result.left_sample  = {data_byte ^ wavd_pkg::SAMPLE_BIAS, 8'd0};
              result.right_sample = {data_byte ^ wavd_pkg::SAMPLE_BIAS, 8'd0};
            end else if (fb == 3'd2 && bits_held == 5'd8) begin
              result.left_sample  = {frame_held[7:0] ^ wavd_pkg::SAMPLE_BIAS, 8'd0};
              result.right_sample = {data_byte ^ wavd_pkg::SAMPLE_BIAS, 8'd0};
            end else if (fb == 3'd2) begin
              result.left_sample  = {data_byte, frame_held[7:0]};
              result.right_sample = {data_byte, frame_held[7:0]};
            end else begin
              result.left_sample  = {frame_held[15:8], frame_held[23:16]};
              result.right_sample = {data_byte, frame_held[7:0]};
            end
          end
        end
        wavd_pkg::PH_SKIP: ;
        wavd_pkg::PH_IDLE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= wavd_pkg::PH_RIFF;
      byte_count     <= '0;
      chunk_length   <= '0;
      tag_shift      <= '0;
      format_code    <= '0;
      channels_held  <= '0;
      rate_held      <= '0;
      bits_held      <= '0;
      format_seen    <= 1'b0;
      data_remaining <= '0;
      frame_held     <= '0;
      frame_idx      <= '0;
    end else if (step) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      chunk_length   <= chunk_length_next;
      tag_shift      <= tag_shift_next;
      format_code    <= format_code_next;
      channels_held  <= channels_held_next;
      rate_held      <= rate_held_next;
      bits_held      <= bits_held_next;
      format_seen    <= format_seen_next;
      data_remaining <= data_remaining_next;
      frame_held     <= frame_held_next;
      frame_idx      <= frame_idx_next;
    end
  end

  a_end_rearms: assert property (@(posedge clk) disable iff (rst)
    step && stream_end |=> phase == wavd_pkg::PH_RIFF)
    else $error("stream end did not rearm the parser");

  a_seen_bits: assert property (@(posedge clk) disable iff (rst)
    format_seen |-> (bits_held == 5'd8 || bits_held == 5'd16))
    else $error("format marked seen with bad sample width");

  a_data_left: assert property (@(posedge clk) disable iff (rst)
    phase == wavd_pkg::PH_DATA |-> data_remaining != 32'd0)
    else $error("data phase with no bytes left");

  a_frame_idx: assert property (@(posedge clk) disable iff (rst)
    phase == wavd_pkg::PH_DATA |-> ({1'b0, frame_idx} < fb))
    else $error("frame byte index ran past frame size");

endmodule

// ===== dv/wav_pcm_stream_decoder_check.sv =====
// wav_pcm_stream_decoder_check: watches the byte and result channels of the decoder,
// predicts every result beat and compares it field by field.
// Depends on wavd_pkg for the phase enum, the result struct, tags and codes.
module wav_pcm_stream_decoder_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               byte_stall,
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [1:0]         kind,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic [31:0]        pcm_rate,
  input  logic [1:0]         channel_count,
  input  logic [4:0]         sample_bits,
  input  logic [2:0]         error_code,
  input  logic               is_last,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_checked
);

  localparam int PRINT_CAP = 40;

  // Parser copy
  wavd_pkg::phase_t ph;
  logic [31:0] byte_cnt;
  logic [32:0] chunk_left;
  logic [31:0] tag_sr;
  logic [15:0] fmt_code;
  logic [1:0]  chans;
  logic [31:0] rate;
  logic [4:0]  bits;
  logic        fmt_valid;
  logic [31:0] data_left;
  logic [23:0] frame_hold;
  logic [1:0]  frame_idx;

  wavd_pkg::result_t expected_results[$];
  wavd_pkg::result_t res;
  logic              hit;

  function automatic logic [31:0] le32(input logic [31:0] t);
    return {t[7:0], t[15:8], t[23:16], t[31:24]};
  endfunction

  function automatic logic [15:0] le16(input logic [31:0] t);
    return {t[7:0], t[15:8]};
  endfunction

  function automatic int frame_len();
    int fb;
    fb = (int'(chans) * int'(bits)) / 8;
    if (fb == 0 || fb > 4) fb = 1;
    return fb;
  endfunction

  task automatic clear_parse();
    ph         = wavd_pkg::PH_RIFF;
    byte_cnt   = '0;
    chunk_left = '0;
    tag_sr     = '0;
    fmt_code   = '0;
    chans      = '0;
    rate       = '0;
    bits       = '0;
    fmt_valid  = 1'b0;
    data_left  = '0;
    frame_hold = '0;
    frame_idx  = '0;
  endtask

  task automatic flag_error(input logic [2:0] code);
    ph             = wavd_pkg::PH_IDLE;
    res.kind       = wavd_pkg::KIND_ERROR;
    res.error_code = code;
    hit            = 1'b1;
  endtask

  // Advance the parser copy by one accepted byte beat; queue the result it makes.
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic [31:0] idx;
    logic [31:0] size;
    logic [31:0] id;
    logic [15:0] v16;
    logic [15:0] l;
    logic [15:0] rr;
    int          fb;
    res = '0;
    hit = 1'b0;
    if (eos) begin
      if (ph == wavd_pkg::PH_DATA || ph == wavd_pkg::PH_IDLE) begin
        res.kind = wavd_pkg::KIND_END;
      end else begin
        res.kind       = wavd_pkg::KIND_ERROR;
        res.error_code = wavd_pkg::ERR_EOS_HDR;
      end
      hit = 1'b1;
      clear_parse();
    end else begin
      case (ph)
        wavd_pkg::PH_RIFF: begin
          tag_sr   = {tag_sr[23:0], b};
          byte_cnt = byte_cnt + 32'd1;
          if (byte_cnt == 32'd4 && tag_sr != wavd_pkg::TAG_RIFF) begin
            flag_error(wavd_pkg::ERR_BAD_TAG);
          end else if (byte_cnt >= 32'd12) begin
            if (tag_sr != wavd_pkg::TAG_WAVE) begin
              flag_error(wavd_pkg::ERR_BAD_TAG);
            end else begin
              ph       = wavd_pkg::PH_HDR;
              byte_cnt = '0;
            end
          end
        end
        wavd_pkg::PH_HDR: begin
          tag_sr   = {tag_sr[23:0], b};
          byte_cnt = byte_cnt + 32'd1;
          if (byte_cnt == 32'd4) begin
            chunk_left = {1'b0, tag_sr};
          end else if (byte_cnt >= 32'd8) begin
            size     = le32(tag_sr);
            id       = chunk_left[31:0];
            byte_cnt = '0;
            if (id == wavd_pkg::TAG_FMT) begin
              if (size < wavd_pkg::FMT_MIN_LEN) begin
                flag_error(wavd_pkg::ERR_SHORT_FMT);
              end else begin
                chunk_left = {1'b0, size};
                ph         = wavd_pkg::PH_FMT;
              end
            end else if (id == wavd_pkg::TAG_DATA) begin
              if (!fmt_valid) begin
                flag_error(wavd_pkg::ERR_NO_FMT);
              end else begin
                data_left  = size;
                frame_idx  = '0;
                frame_hold = '0;
                if (size != 32'd0) ph = wavd_pkg::PH_DATA;
                else ph = wavd_pkg::PH_IDLE;
                res.kind          = wavd_pkg::KIND_FORMAT;
                res.pcm_rate      = rate;
                res.channel_count = chans;
                res.sample_bits   = bits;
                res.is_last       = (size < 32'(frame_len()));
                hit               = 1'b1;
              end
            end else begin
              // skipped chunks carry their pad byte
              chunk_left = {1'b0, size} + {32'd0, size[0]};
              if (chunk_left != 33'd0) ph = wavd_pkg::PH_SKIP;
            end
          end
        end
        wavd_pkg::PH_FMT: begin
          idx    = byte_cnt;
          tag_sr = {tag_sr[23:0], b};
          if (byte_cnt < wavd_pkg::FMT_MIN_LEN) byte_cnt = byte_cnt + 32'd1;
          chunk_left = chunk_left - 33'd1;
          case (idx)
            32'd1: fmt_code = le16(tag_sr);
            32'd3: begin
              v16   = le16(tag_sr);
              chans = (v16 == 16'd1 || v16 == 16'd2) ? v16[1:0] : 2'd0;
            end
            32'd7: rate = le32(tag_sr);
            32'd15: begin
              v16 = le16(tag_sr);
              if (fmt_code != wavd_pkg::FMT_PCM || (v16 != 16'd8 && v16 != 16'd16) ||
                  chans == 2'd0) begin
                flag_error(wavd_pkg::ERR_FORMAT);
              end else begin
                bits      = v16[4:0];
                fmt_valid = 1'b1;
              end
            end
            default: ;
          endcase
          if (!hit && chunk_left == 33'd0) begin
            ph       = wavd_pkg::PH_HDR;
            byte_cnt = '0;
          end
        end
        wavd_pkg::PH_SKIP: begin
          chunk_left = chunk_left - 33'd1;
          if (chunk_left == 33'd0) begin
            ph       = wavd_pkg::PH_HDR;
            byte_cnt = '0;
          end
        end
        wavd_pkg::PH_DATA: begin
          fb        = frame_len();
          data_left = data_left - 32'd1;
          if (int'(frame_idx) + 1 >= fb) begin
            if (fb == 1) begin
              l  = {b ^ wavd_pkg::SAMPLE_BIAS, 8'h00};
              rr = l;
            end else if (fb == 2) begin
              if (bits == 5'd8) begin
                l  = {frame_hold[7:0] ^ wavd_pkg::SAMPLE_BIAS, 8'h00};
                rr = {b ^ wavd_pkg::SAMPLE_BIAS, 8'h00};
              end else begin
                l  = {b, frame_hold[7:0]};
                rr = l;
              end
            end else begin
              l  = {frame_hold[15:8], frame_hold[23:16]};
              rr = {b, frame_hold[7:0]};
            end
            res.kind         = wavd_pkg::KIND_FRAME;
            res.left_sample  = l;
            res.right_sample = rr;
            res.is_last      = (data_left < 32'(fb));
            hit              = 1'b1;
            frame_idx        = '0;
            frame_hold       = '0;
          end else begin
            frame_hold = {frame_hold[15:0], b};
            frame_idx  = frame_idx + 2'd1;
          end
          if (data_left == 32'd0) ph = wavd_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
    if (hit) expected_results.push_back(res);
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] result beat %0d: %s expected %0h, got %0h",
               $time, results_checked, what, want, got);
  endtask

  task automatic check_beat();
    wavd_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report("unexpected beat, kind", 32'hx, 32'(kind));
    end else begin
      want = expected_results.pop_front();
      if (kind !== want.kind) report("kind", 32'(want.kind), 32'(kind));
      if (left_sample !== want.left_sample)
        report("left_sample", 32'(want.left_sample), 32'(left_sample));
      if (right_sample !== want.right_sample)
        report("right_sample", 32'(want.right_sample), 32'(right_sample));
      if (pcm_rate !== want.pcm_rate) report("pcm_rate", want.pcm_rate, pcm_rate);
      if (channel_count !== want.channel_count)
        report("channel_count", 32'(want.channel_count), 32'(channel_count));
      if (sample_bits !== want.sample_bits)
        report("sample_bits", 32'(want.sample_bits), 32'(sample_bits));
      if (error_code !== want.error_code)
        report("error_code", 32'(want.error_code), 32'(error_code));
      if (is_last !== want.is_last) report("is_last", 32'(want.is_last), 32'(is_last));
    end
    results_checked++;
  endtask

  // Predict first: a result beat never stems from a byte taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_results.delete();
    end else begin
      if (byte_valid && !byte_stall) decode_byte(data_byte, stream_end);
      if (result_valid && !result_stall) check_beat();
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== dv/wav_pcm_stream_decoder_test.sv =====
// wav_pcm_stream_decoder_test: top of the decoder testbench. Builds WAVE files byte by
// byte, drives them with random gaps and stalls, and gives the verdict.
// Depends on wavd_pkg, wav_pcm_stream_decoder and wav_pcm_stream_decoder_check.
module wav_pcm_stream_decoder_test;

  // Cycles with no accepted beat on either channel before the run is declared hung.
  localparam int HANG_LIMIT  = 2000;
  localparam int TOTAL_BYTES = 600;
  localparam int TAIL_CYCLES = 8;

  // A chunk id that is neither fmt nor data, used for oversized skip chunks.
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

  // Shapes of a random file; everything past SHAPE_CUT_HEADER is well formed.
  typedef enum int {
    SHAPE_NOISE,
    SHAPE_BAD_RIFF,
    SHAPE_BAD_WAVE,
    SHAPE_DATA_FIRST,
    SHAPE_SHORT_FMT,
    SHAPE_BAD_FORMAT,
    SHAPE_HUGE_CHUNK,
    SHAPE_CUT_HEADER,
    SHAPE_GOOD
  } file_shape_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               byte_valid = 1'b0;
  logic               byte_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               stream_end = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         kind;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [31:0]        pcm_rate;
  logic [1:0]         channel_count;
  logic [4:0]         sample_bits;
  logic [2:0]         error_code;
  logic               is_last;

  int errors;
  int pending;
  int results_seen;
  int bytes_sent;
  int files_sent;
  int directed_bytes;
  int quiet_cycles;
  bit gaps_on;

  // The file under construction, first byte at the front.
  logic [7:0] wave_q[$];

  always #5 clk = ~clk;

  wav_pcm_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .data_byte     (data_byte),
    .stream_end    (stream_end),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .left_sample   (left_sample),
    .right_sample  (right_sample),
    .pcm_rate      (pcm_rate),
    .channel_count (channel_count),
    .sample_bits   (sample_bits),
    .error_code    (error_code),
    .is_last       (is_last)
  );

  wav_pcm_stream_decoder_check checker_i (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .stream_end      (stream_end),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .kind            (kind),
    .left_sample     (left_sample),
    .right_sample    (right_sample),
    .pcm_rate        (pcm_rate),
    .channel_count   (channel_count),
    .sample_bits     (sample_bits),
    .error_code      (error_code),
    .is_last         (is_last),
    .mismatches      (errors),
    .outstanding     (pending),
    .results_checked (results_seen)
  );

  // ---------------------------------------------------------------------------
  // File building: append to wave_q
  // ---------------------------------------------------------------------------

  // Tags go out first character first.
  function automatic void put_tag(input logic [31:0] t);
    wave_q.push_back(t[31:24]);
    wave_q.push_back(t[23:16]);
    wave_q.push_back(t[15:8]);
    wave_q.push_back(t[7:0]);
  endfunction

  // Little-endian field of n bytes.
  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) wave_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_noise(input int n);
    for (int i = 0; i < n; i++) wave_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_riff();
    put_tag(wavd_pkg::TAG_RIFF);
    put_le($urandom, 4);
    put_tag(wavd_pkg::TAG_WAVE);
  endfunction

  // fmt chunk with a given length field; extra bytes follow the 16-byte body.
  function automatic void put_fmt(input logic [15:0] code, input logic [15:0] ch,
                                  input logic [15:0] nbits, input logic [31:0] rate,
                                  input logic [31:0] len, input int extra);
    put_tag(wavd_pkg::TAG_FMT);
    put_le(len, 4);
    put_le({16'd0, code}, 2);
    put_le({16'd0, ch}, 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le({16'd0, nbits}, 2);
    put_noise(extra);
  endfunction

  // Unknown chunk with random body, padded to an even length.
  function automatic void put_junk(input int len);
    logic [31:0] id;
    do id = $urandom; while (id == wavd_pkg::TAG_FMT || id == wavd_pkg::TAG_DATA);
    put_tag(id);
    put_le(32'(len), 4);
    put_noise(len + (len % 2));
  endfunction

  task automatic compose_random();
    file_shape_t shape;
    int          pick;
    int          ch;
    int          nb;
    int          fb;
    int          extra;
    int          hdr_len;
    int          cut;
    int          n;
    logic [31:0] size;
    logic [15:0] code;
    logic [15:0] bad_ch;
    logic [15:0] bad_bits;
    wave_q.delete();
    pick = $urandom_range(0, 19);
    if (pick < int'(SHAPE_GOOD)) shape = file_shape_t'(pick);
    else shape = SHAPE_GOOD;
    ch = $urandom_range(1, 2);
    nb = $urandom_range(0, 1) ? 16 : 8;
    fb = ch * nb / 8;
    case (shape)
      SHAPE_NOISE: put_noise($urandom_range(0, 6));
      SHAPE_BAD_RIFF: begin
        put_tag(wavd_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
        put_noise($urandom_range(0, 4));
      end
      SHAPE_BAD_WAVE: begin
        put_tag(wavd_pkg::TAG_RIFF);
        put_le($urandom, 4);
        put_tag(wavd_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)));
        put_noise($urandom_range(0, 4));
      end
      SHAPE_DATA_FIRST: begin
        put_riff();
        put_tag(wavd_pkg::TAG_DATA);
        put_le($urandom_range(0, 8), 4);
        put_noise($urandom_range(0, 8));
      end
      SHAPE_SHORT_FMT: begin
        put_riff();
        if ($urandom_range(0, 2) == 0) put_junk($urandom_range(0, 9));
        put_tag(wavd_pkg::TAG_FMT);
        put_le($urandom_range(0, 15), 4);
        put_noise($urandom_range(0, 4));
      end
      SHAPE_BAD_FORMAT: begin
        // spoil exactly one of code, channels, bits
        code     = wavd_pkg::FMT_PCM;
        bad_ch   = 16'(ch);
        bad_bits = 16'(nb);
        case ($urandom_range(0, 2))
          0: begin
            code = 16'($urandom_range(0, 65535));
            if (code == wavd_pkg::FMT_PCM) code = 16'd3;
          end
          1: bad_ch = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(3, 65535));
          default: begin
            bad_bits = 16'($urandom_range(0, 65535));
            if (bad_bits == 16'd8 || bad_bits == 16'd16) bad_bits = 16'd24;
          end
        endcase
        put_riff();
        put_fmt(code, bad_ch, bad_bits, $urandom, 32'd16, 0);
        put_noise($urandom_range(0, 6));
      end
      SHAPE_HUGE_CHUNK: begin
        // a chunk far longer than the stream: end arrives mid-chunk
        put_riff();
        if ($urandom_range(0, 1)) begin
          put_tag(TAG_LIST);
          put_le(32'hFFFF_FFF0 | $urandom_range(0, 15), 4);
        end else begin
          put_fmt(wavd_pkg::FMT_PCM, 16'(ch), 16'(nb), $urandom, 32'hFFFF_FFFF, 0);
        end
        put_noise($urandom_range(0, 20));
      end
      default: begin
        put_riff();
        if ($urandom_range(0, 3) == 0) put_junk($urandom_range(0, 9));
        // an earlier fmt chunk that the later one overrides
        if ($urandom_range(0, 4) == 0)
          put_fmt(wavd_pkg::FMT_PCM, 16'(3 - ch), (nb == 8) ? 16'd16 : 16'd8, $urandom,
                  32'd16, 0);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        put_fmt(wavd_pkg::FMT_PCM, 16'(ch), 16'(nb), $urandom, 32'(16 + extra), extra);
        if ($urandom_range(0, 3) == 0) put_junk($urandom_range(0, 9));
        hdr_len = wave_q.size() + 8;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          size = 32'd0;
          n    = 0;
        end else if (pick == 1) begin
          size = 32'hFFFF_FF00 | $urandom_range(0, 255);
          n    = $urandom_range(0, 16);
        end else begin
          size = 32'(fb * $urandom_range(1, 6));
          if ($urandom_range(0, 2) == 0) size = size + $urandom_range(0, fb - 1);
          n = int'(size);
          if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 4);
          else if ($urandom_range(0, 5) == 0) n = $urandom_range(0, int'(size));
        end
        put_tag(wavd_pkg::TAG_DATA);
        put_le(size, 4);
        put_noise(n);
        // drop the tail anywhere before the data header completes
        if (shape == SHAPE_CUT_HEADER) begin
          cut = $urandom_range(0, hdr_len - 1);
          while (wave_q.size() > cut) void'(wave_q.pop_back());
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Byte channel driving
  // ---------------------------------------------------------------------------

  // Offer one beat after a random gap and hold it until taken.
  task automatic send_beat(input logic [7:0] b, input logic eos);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    stream_end <= eos;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
  endtask

  // Send the whole file, then the stream end that rearms the parser.
  task automatic play_file();
    foreach (wave_q[i]) send_beat(wave_q[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    files_sent++;
  endtask

  // Hold off the byte channel until every predicted result beat has come out.
  // Look at the count on the falling edge, clear of the checker's update.
  task automatic drain();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: stall a random number of cycles before each beat
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    forever begin
      hold = gaps_on ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("[%0t] no beat accepted for %0d cycles, %0d results outstanding",
               $time, HANG_LIMIT, pending);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, first without gaps, then with them.
    gaps_on = 1'b0;

    // stream end with no bytes at all
    wave_q.delete();
    play_file();

    // bad RIFF tag, then bytes that must be dropped
    wave_q.delete();
    put_tag(32'h5249_4658);
    put_noise(2);
    play_file();

    gaps_on = 1'b1;

    // bad WAVE tag behind a maximal RIFF size
    wave_q.delete();
    put_tag(wavd_pkg::TAG_RIFF);
    put_le(32'hFFFF_FFFF, 4);
    put_tag(32'h5741_5646);
    play_file();

    // fmt chunk one byte too short
    wave_q.delete();
    put_riff();
    put_tag(wavd_pkg::TAG_FMT);
    put_le(32'd15, 4);
    play_file();

    // float, 32 bits: unsupported format
    wave_q.delete();
    put_riff();
    put_fmt(16'd3, 16'd2, 16'd32, 32'd48000, 32'd16, 0);
    play_file();

    // data chunk before any fmt
    wave_q.delete();
    put_riff();
    put_tag(wavd_pkg::TAG_DATA);
    put_le(32'd4, 4);
    put_noise(4);
    play_file();

    // mono 8-bit at rate zero: samples 00 80 FF 7F, then ignored bytes past the data
    wave_q.delete();
    put_riff();
    put_fmt(wavd_pkg::FMT_PCM, 16'd1, 16'd8, 32'd0, 32'd16, 0);
    put_tag(wavd_pkg::TAG_DATA);
    put_le(32'd4, 4);
    put_le(32'h7FFF_8000, 4);
    put_noise(2);
    play_file();

    // odd junk chunk with pad, fmt with extra bytes, stereo 16-bit at top rate,
    // two frames of extreme samples and a trailing partial frame
    wave_q.delete();
    put_riff();
    put_junk(3);
    put_fmt(wavd_pkg::FMT_PCM, 16'd2, 16'd16, 32'hFFFF_FFFF, 32'd18, 2);
    put_tag(wavd_pkg::TAG_DATA);
    put_le(32'd9, 4);
    put_le(32'h8000_0000, 4);
    put_le(32'hFFFF_7FFF, 4);
    put_le(32'h5A, 1);
    play_file();

    // two fmt chunks, the later stereo 8-bit one holds; empty data chunk
    wave_q.delete();
    put_riff();
    put_fmt(wavd_pkg::FMT_PCM, 16'd2, 16'd16, $urandom, 32'd16, 0);
    put_fmt(wavd_pkg::FMT_PCM, 16'd2, 16'd8, $urandom, 32'd16, 0);
    put_tag(wavd_pkg::TAG_DATA);
    put_le(32'd0, 4);
    put_noise(3);
    play_file();

    // mono 16-bit, huge data chunk cut short: end of stream inside data
    wave_q.delete();
    put_riff();
    put_fmt(wavd_pkg::FMT_PCM, 16'd1, 16'd16, $urandom, 32'd16, 0);
    put_tag(wavd_pkg::TAG_DATA);
    put_le(32'hFFFF_FFFE, 4);
    put_noise(5);
    play_file();

    // stream end inside a skipped chunk
    wave_q.delete();
    put_riff();
    put_tag(TAG_LIST);
    put_le(32'd8, 4);
    put_noise(3);
    play_file();

    directed_bytes = bytes_sent;
    drain();

    // Random files: mostly well formed with random content, the rest broken.
    // Switch gaps off for some files so back-to-back stretches occur too.
    while (bytes_sent < TOTAL_BYTES) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      compose_random();
      play_file();
      if ($urandom_range(0, 4) == 0) drain();
    end

    // Wait out every expected beat, then a few more cycles for stray output.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d byte beats in %0d files (%0d beats directed), %0d result beats",
             bytes_sent, files_sent, directed_bytes, results_seen);
    $display("checked across tag, format, skip, data and stream-end handling; %0d mismatches",
             errors);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wavd_pkg.sv
rtl/core/wavd_parser.sv
rtl/core/wav_pcm_stream_decoder.sv
dv/wav_pcm_stream_decoder_check.sv
dv/wav_pcm_stream_decoder_test.sv
